/* rtl/core/tes_pkg.sv */
package tes_pkg;

  localparam int unsigned SampleMax = 1024;
  localparam int unsigned CntW      = $clog2(SampleMax + 1);
  localparam int unsigned PairW     = $clog2(SampleMax / 2 + 1);
  localparam int unsigned CmpW      = CntW + 3;
  localparam int unsigned HeadBytes = 3;

  localparam logic [7:0] BomFe  = 8'hfe;
  localparam logic [7:0] BomFf  = 8'hff;
  localparam logic [7:0] BomEf  = 8'hef;
  localparam logic [7:0] BomBb  = 8'hbb;
  localparam logic [7:0] BomBf  = 8'hbf;

  typedef enum logic [2:0] {
    ENC_NONE     = 3'd0,
    ENC_UTF16_BE = 3'd1,
    ENC_UTF16_LE = 3'd2,
    ENC_UTF8     = 3'd3,
    ENC_SJIS     = 3'd4
  } encoding_class_e;

  typedef struct packed {
    logic [8*HeadBytes-1:0] head;
    logic [CntW-1:0]        count;
    logic [PairW-1:0]       pairs;
  } sample_t;

  function automatic logic sj_lead(input logic [7:0] b);
    return b inside {[8'd129:8'd159], [8'd224:8'd239]};
  endfunction

  function automatic logic sj_trail(input logic [7:0] b);
    return b inside {[8'd64:8'd126], [8'd128:8'd252]};
  endfunction

endpackage

/* rtl/core/tes_classify.sv */
module tes_classify (
  input  tes_pkg::sample_t         sample_i,
  output tes_pkg::encoding_class_e class_o
);
  import tes_pkg::*;

  logic [7:0]      b0, b1, b2;
  logic [CmpW-1:0] pairs_w;
  logic [CmpW-1:0] bound;
  logic            two_plus;
  logic            three_plus;
  logic            sjis_ok;

  assign b0         = sample_i.head[7:0];
  assign b1         = sample_i.head[15:8];
  assign b2         = sample_i.head[23:16];
  assign two_plus   = sample_i.count >= CntW'(2);
  assign three_plus = sample_i.count >= CntW'(3);
  assign pairs_w    = CmpW'(sample_i.pairs);
  // pairs >= count/6  <=>  6*pairs + 6 > count
  assign bound      = (pairs_w << 2) + (pairs_w << 1) + CmpW'(6);
  assign sjis_ok    = (sample_i.pairs != '0) && (bound > CmpW'(sample_i.count));

  always_comb begin
    class_o = ENC_NONE;
    if (two_plus && b0 == BomFe && b1 == BomFf) begin
      class_o = ENC_UTF16_BE;
    end else if (two_plus && b0 == BomFf && b1 == BomFe) begin
      class_o = ENC_UTF16_LE;
    end else if (three_plus && b0 == BomEf && b1 == BomBb && b2 == BomBf) begin
      class_o = ENC_UTF8;
    end else if (two_plus && sjis_ok) begin
      class_o = ENC_SJIS;
    end
  end

endmodule

/* rtl/core/text_encoding_sniffer.sv */
// Text encoding sniffer.
// Input channel: one sample byte per beat on data_byte_i, with last_byte_i
// marking the final byte of a sample. A beat is taken when in_valid_i is
// high and in_stall_o is low. Only the first SampleMax bytes are examined;
// later bytes are dropped but their last flag still closes the sample.
// Output channel: one encoding_class_o beat per sample, taken when
// out_valid_o is high and out_stall_i is low.
// Throughput: one byte per cycle while in_stall_o is low; samples may follow
// each other with no gap. After the last byte is taken, the updated head,
// byte count and pair count are registered as a sample snapshot, which is
// classified into the output register once that register is free.
// Stall: a valid class in the output register holds while out_stall_i is
// high; one finished snapshot waits behind it, and in_stall_o rises only
// while that snapshot cannot advance.
// Reset: rst_ni clears all counters, the pending byte and both valid flags.
module text_encoding_sniffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] encoding_class_o
);
  import tes_pkg::*;

  logic [8*HeadBytes-1:0] head_q, head_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [PairW-1:0]       pairs_q, pairs_d;
  logic [7:0]             pend_q, pend_d;
  logic                   pend_valid_q, pend_valid_d;

  sample_t                fin_q, fin_d;
  logic                   fin_valid_q, fin_valid_d;
  encoding_class_e        class_q, class_w;
  logic                   out_valid_q, out_valid_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = fin_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign take       = count_q < CntW'(SampleMax);

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    pairs_d      = pairs_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (take) begin
      for (int k = 0; k < HeadBytes; k++) begin
        if (count_q == CntW'(k)) begin
          head_d[8*k +: 8] = data_byte_i;
        end
      end
      count_d = count_q + CntW'(1);
      if (pend_valid_q && sj_lead(pend_q) && sj_trail(data_byte_i)) begin
        pairs_d      = pairs_q + PairW'(1);
        pend_valid_d = 1'b0;
        pend_d       = '0;
      end else begin
        pend_d       = data_byte_i;
        pend_valid_d = 1'b1;
      end
    end
  end

  always_comb begin
    fin_d       = fin_q;
    fin_valid_d = fin_valid_q && !out_free;
    if (in_acc && last_byte_i) begin
      fin_d.head  = head_d;
      fin_d.count = count_d;
      fin_d.pairs = pairs_d;
      fin_valid_d = 1'b1;
    end
  end

  assign out_valid_d = out_free ? fin_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      pairs_q      <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      fin_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        if (last_byte_i) begin
          head_q       <= '0;
          count_q      <= '0;
          pairs_q      <= '0;
          pend_q       <= '0;
          pend_valid_q <= 1'b0;
        end else begin
          head_q       <= head_d;
          count_q      <= count_d;
          pairs_q      <= pairs_d;
          pend_q       <= pend_d;
          pend_valid_q <= pend_valid_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    if (out_free && fin_valid_q) begin
      class_q <= class_w;
    end
  end

  tes_classify u_classify (
    .sample_i (fin_q),
    .class_o  (class_w)
  );

  assign out_valid_o      = out_valid_q;
  assign encoding_class_o = class_q;

`ifndef SYNTHESIS
  a_stall_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input not stalled while snapshot is blocked");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> fin_valid_q && count_q == '0 && !pend_valid_q)
    else $error("sample state not cleared after last byte");

  a_pairs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CntW + 1)'(pairs_q) << 1) <= (CntW + 1)'(count_q))
    else $error("pair count exceeds half the byte count");

  a_fin_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && (!out_valid_q || !out_stall_i) |=> out_valid_q)
    else $error("finished sample did not reach output register");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tes_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOff    = 300;
  localparam int unsigned ShortBytes = 370;

  class sniff_scoreboard;
    logic [7:0]        head [HeadBytes];
    int unsigned       count;
    int unsigned       pairs;
    logic [7:0]        pend;
    bit                pend_valid;
    encoding_class_e   expected_classes [$];
    int unsigned       errors;
    int unsigned       class_seen [5];

    function new();
      clear();
      errors = 0;
      class_seen = '{default: 0};
    endfunction

    function void clear();
      head = '{default: 8'd0};
      count = 0;
      pairs = 0;
      pend = 8'd0;
      pend_valid = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, bit last);
      encoding_class_e cls;
      int unsigned     need;
      if (count < SampleMax) begin
        if (count < HeadBytes) head[count] = b;
        count++;
        if (pend_valid && ((pend >= 129 && pend <= 159) || (pend >= 224 && pend <= 239)) &&
            ((b >= 64 && b <= 158 && b != 127) || (b >= 159 && b <= 252))) begin
          pairs++;
          pend_valid = 1'b0;
          pend = 8'd0;
        end else begin
          pend = b;
          pend_valid = 1'b1;
        end
      end
      if (last) begin
        need = (count / 6 > 1) ? count / 6 : 1;
        if (count >= 2 && head[0] == BomFe && head[1] == BomFf) begin
          cls = ENC_UTF16_BE;
        end else if (count >= 2 && head[0] == BomFf && head[1] == BomFe) begin
          cls = ENC_UTF16_LE;
        end else if (count >= 3 && head[0] == BomEf && head[1] == BomBb && head[2] == BomBf) begin
          cls = ENC_UTF8;
        end else if (count >= 2 && pairs >= need) begin
          cls = ENC_SJIS;
        end else begin
          cls = ENC_NONE;
        end
        expected_classes.push_back(cls);
        clear();
      end
    endfunction

    function void check_class(logic [2:0] got);
      encoding_class_e want;
      if (expected_classes.size() == 0) begin
        $error("encoding_class: unexpected beat, expected none, actual %0d", got);
        errors++;
      end else begin
        want = expected_classes.pop_front();
        if (got !== want) begin
          $error("encoding_class: expected %0d, actual %0d", want, got);
          errors++;
        end else begin
          class_seen[want]++;
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'd0;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;
  logic [2:0] encoding_class_o;

  sniff_scoreboard sb = new();
  logic [7:0]      sample_q [$];
  int unsigned     bytes_sent;
  int unsigned     samples_sent;
  int unsigned     backpressure_cycles;
  int unsigned     cycles;

  text_encoding_sniffer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .encoding_class_o (encoding_class_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] pick_byte(input int kind);
    logic [7:0] b;
    case (kind)
      1: b = $urandom_range(0, 1) ? 8'($urandom_range(129, 159)) : 8'($urandom_range(224, 239));
      2: begin
        b = 8'($urandom_range(64, 252));
        if (b == 8'd127) b = 8'd128;
      end
      3: begin
        case ($urandom_range(0, 15))
          0: b = 8'd0;
          1: b = 8'd63;
          2: b = 8'd64;
          3: b = 8'd126;
          4: b = 8'd127;
          5: b = 8'd128;
          6: b = 8'd129;
          7: b = 8'd158;
          8: b = 8'd159;
          9: b = 8'd160;
          10: b = 8'd223;
          11: b = 8'd224;
          12: b = 8'd239;
          13: b = 8'd240;
          14: b = 8'd252;
          default: b = 8'd253;
        endcase
      end
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  task automatic send_sample(input bit quiet);
    int gap;
    foreach (sample_q[i]) begin
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      data_byte_i <= sample_q[i];
      last_byte_i <= (i == sample_q.size() - 1);
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      sb.take_byte(sample_q[i], i == sample_q.size() - 1);
      @(negedge clk_i);
    end
    bytes_sent += sample_q.size();
    samples_sent++;
  endtask

  task automatic send_short(input int n, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2);
    sample_q.delete();
    sample_q.push_back(b0);
    if (n > 1) sample_q.push_back(b1);
    if (n > 2) sample_q.push_back(b2);
    send_sample(1'b1);
  endtask

  // hold off long enough for the block to fill and stall its input
  initial begin : receiver
    int  k;
    int  left;
    bit  steady;
    left = 0;
    steady = 1'b0;
    wait (rst_ni);
    repeat (HoldOff) @(negedge clk_i);
    forever begin
      if (left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        left = 10;
      end
      left--;
      k = steady ? 0 : $urandom_range(0, 13);
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_class(encoding_class_o);
    if (in_valid_i && in_stall_o) backpressure_cycles++;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned short_bytes;
    bytes_sent = 0;
    samples_sent = 0;
    backpressure_cycles = 0;
    cycles = 0;
    short_bytes = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_short(1, 8'd0, 8'd0, 8'd0);
    send_short(1, 8'd255, 8'd0, 8'd0);
    send_short(2, BomFe, BomFf, 8'd0);
    send_short(2, BomFf, BomFe, 8'd0);
    send_short(3, BomEf, BomBb, BomBf);
    send_short(2, BomEf, BomBb, 8'd0);
    send_short(2, 8'd129, 8'd64, 8'd0);
    send_short(2, 8'd159, 8'd252, 8'd0);
    send_short(2, 8'd239, 8'd158, 8'd0);
    send_short(2, 8'd129, 8'd127, 8'd0);
    send_short(2, 8'd240, 8'd64, 8'd0);
    send_short(2, 8'd128, 8'd253, 8'd0);
    send_short(3, 8'd224, 8'd129, 8'd64);
    send_short(3, 8'd129, 8'd129, 8'd64);

    while (short_bytes < ShortBytes) begin
      sample_q.delete();
      case ($urandom_range(0, 9))
        0, 1: begin
          case ($urandom_range(0, 4))
            0: begin
              sample_q.push_back(BomFe);
              sample_q.push_back(BomFf);
            end
            1: begin
              sample_q.push_back(BomFf);
              sample_q.push_back(BomFe);
            end
            2: begin
              sample_q.push_back(BomEf);
              sample_q.push_back(BomBb);
              sample_q.push_back(BomBf);
            end
            3: begin
              sample_q.push_back(BomEf);
              sample_q.push_back(BomBb);
            end
            default: sample_q.push_back(BomEf);
          endcase
          n = $urandom_range(0, 8);
          repeat (n) sample_q.push_back(pick_byte($urandom_range(0, 3)));
        end
        2, 3, 4, 5: begin
          n = $urandom_range(1, 10);
          repeat (n) begin
            if ($urandom_range(0, 4) != 0) begin
              sample_q.push_back(pick_byte(1));
              sample_q.push_back(pick_byte($urandom_range(0, 5) == 0 ? 3 : 2));
            end else begin
              sample_q.push_back(pick_byte($urandom_range(0, 1) ? 0 : 3));
            end
          end
        end
        6: sample_q.push_back(pick_byte($urandom_range(0, 3)));
        default: begin
          n = $urandom_range(1, 16);
          repeat (n) sample_q.push_back(pick_byte($urandom_range(0, 3)));
        end
      endcase
      short_bytes += sample_q.size();
      send_sample($urandom_range(0, 3) == 0);
    end
    in_valid_i <= 1'b0;
    last_byte_i <= 1'b0;

    while (sb.expected_classes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d samples (%0d bytes); input held back for %0d cycles.",
             samples_sent, bytes_sent, backpressure_cycles);
    $display("Classes matched: none %0d, utf16be %0d, utf16le %0d, utf8 %0d, shift-jis %0d",
             sb.class_seen[ENC_NONE], sb.class_seen[ENC_UTF16_BE], sb.class_seen[ENC_UTF16_LE],
             sb.class_seen[ENC_UTF8], sb.class_seen[ENC_SJIS]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
